>>> hw/rtl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// shared constants and the control type for the sliding window min/max/sum block
// ----------------------------------------------------------------------------
package swmm_pkg;

	localparam int WINDOW_MAX_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int CFG_WIDTH        = 7;
	localparam int TOTAL_WIDTH      = 48;

	localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RST = 7'd4;

	// per-sample control broadcast to every deque cell
	typedef struct packed {
		logic load;   // sample transfer this cycle
		logic start;  // sequence restarts before this sample
		logic last;   // sequence ends after this sample
	} swmm_ctrl_t;

endpackage

>>> hw/rtl/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// one deque entry: value, position and valid, with local pop/expire/shift
// ----------------------------------------------------------------------------
module swmm_cell import swmm_pkg::*; #(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter bit IS_MAX       = 1'b1,
	localparam int PW          = $clog2(2 * WINDOW_MAX),
	localparam int POS_MOD     = 2 * WINDOW_MAX
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swmm_ctrl_t                     ctrl,
	input  logic                           shift,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic        [PW-1:0]           pos,
	input  logic        [PW-1:0]           k,
	input  logic                           right_valid,
	input  logic signed [SAMPLE_WIDTH-1:0] right_value,
	input  logic        [PW-1:0]           right_pos,
	input  logic                           left_keep,
	output logic                           valid_q,
	output logic signed [SAMPLE_WIDTH-1:0] value_q,
	output logic        [PW-1:0]           pos_q,
	output logic                           keep,
	output logic                           expired
);

	logic                           src_valid;
	logic signed [SAMPLE_WIDTH-1:0] src_value;
	logic        [PW-1:0]           src_pos;
	logic        [PW-1:0]           push_pos;
	logic                           popped;
	logic        [PW:0]             diff;
	logic        [PW-1:0]           age;

	always_comb begin
		src_valid = (shift ? right_valid : valid_q) & ~ctrl.start;
		src_value = shift ? right_value : value_q;
		src_pos   = shift ? right_pos : pos_q;
		popped    = IS_MAX ? (src_value <= sample) : (src_value >= sample);
		keep      = src_valid & ~popped;
		push_pos  = ctrl.start ? '0 : pos;
		// modular age of this entry
		diff = {1'b0, pos} - {1'b0, pos_q};
		if (diff[PW]) begin
			age = PW'(diff + (PW+1)'(POS_MOD));
		end else begin
			age = diff[PW-1:0];
		end
		expired = valid_q && (age >= k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load) begin
			valid_q <= ctrl.last ? 1'b0 : (keep | left_keep);
		end else if (shift) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			if (keep) begin
				value_q <= src_value;
				pos_q   <= src_pos;
			end else begin
				value_q <= sample;
				pos_q   <= push_pos;
			end
		end else if (shift) begin
			value_q <= right_value;
			pos_q   <= right_pos;
		end
	end

endmodule

>>> hw/rtl/swmm_chain.sv
// ----------------------------------------------------------------------------
// swmm_chain
// monotonic deque as a row of cells, front entry in cell zero
// ----------------------------------------------------------------------------
module swmm_chain import swmm_pkg::*; #(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter bit IS_MAX       = 1'b1,
	localparam int PW          = $clog2(2 * WINDOW_MAX)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swmm_ctrl_t                     ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic        [PW-1:0]           pos,
	input  logic        [PW-1:0]           k,
	output logic signed [SAMPLE_WIDTH-1:0] front_value,
	output logic                           front_valid,
	output logic                           trim_need
);

	logic                           vld  [0:WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] val  [0:WINDOW_MAX];
	logic        [PW-1:0]           psn  [0:WINDOW_MAX];
	logic                           expd [0:WINDOW_MAX];
	logic                           keep [0:WINDOW_MAX-1];
	logic                           shift;

	// empty sentinel past the last cell
	assign vld[WINDOW_MAX]  = 1'b0;
	assign val[WINDOW_MAX]  = '0;
	assign psn[WINDOW_MAX]  = '0;
	assign expd[WINDOW_MAX] = 1'b0;

	// expired entries form a prefix; a sample drops at most one of them
	assign shift       = expd[0] && (ctrl.load ? !ctrl.start : expd[1]);
	assign trim_need   = expd[0] && expd[1];
	assign front_value = keep[0] ? (shift ? val[1] : val[0]) : sample;
	assign front_valid = vld[0];

	for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
		logic left_keep;
		if (j == 0) begin : g_head
			assign left_keep = 1'b1;
		end else begin : g_body
			assign left_keep = keep[j-1];
		end

		swmm_cell #(
			.WINDOW_MAX  (WINDOW_MAX),
			.SAMPLE_WIDTH(SAMPLE_WIDTH),
			.IS_MAX      (IS_MAX)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.shift      (shift),
			.sample     (sample),
			.pos        (pos),
			.k          (k),
			.right_valid(vld[j+1]),
			.right_value(val[j+1]),
			.right_pos  (psn[j+1]),
			.left_keep  (left_keep),
			.valid_q    (vld[j]),
			.value_q    (val[j]),
			.pos_q      (psn[j]),
			.keep       (keep[j]),
			.expired    (expd[j])
		);
	end

endmodule

>>> hw/rtl/swmm_acc.sv
// ----------------------------------------------------------------------------
// swmm_acc
// pair sum, saturating running total and output register
// ----------------------------------------------------------------------------
module swmm_acc import swmm_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic                           start,
	input  logic                           last,
	input  logic                           has_result,
	input  logic signed [SAMPLE_WIDTH-1:0] min_in,
	input  logic signed [SAMPLE_WIDTH-1:0] max_in,
	input  logic                           out_stall,
	output logic                           ready,
	output logic                           out_valid,
	output logic signed [SAMPLE_WIDTH-1:0] window_min,
	output logic signed [SAMPLE_WIDTH-1:0] window_max,
	output logic signed [SAMPLE_WIDTH:0]   pair_sum,
	output logic signed [TOTAL_WIDTH-1:0]  running_total,
	output logic                           is_last
);

	logic signed [TOTAL_WIDTH-1:0] total_q;
	logic signed [TOTAL_WIDTH-1:0] base;
	logic signed [SAMPLE_WIDTH:0]  pair;
	logic signed [TOTAL_WIDTH:0]   sum;
	logic signed [TOTAL_WIDTH-1:0] sat;

	always_comb begin
		base = start ? '0 : total_q;
		pair = (SAMPLE_WIDTH+1)'(min_in) + (SAMPLE_WIDTH+1)'(max_in);
		sum  = (TOTAL_WIDTH+1)'(base) + (TOTAL_WIDTH+1)'(pair);
		if (sum[TOTAL_WIDTH] != sum[TOTAL_WIDTH-1]) begin
			sat = sum[TOTAL_WIDTH] ? {1'b1, {(TOTAL_WIDTH-1){1'b0}}}
			                       : {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
		end else begin
			sat = sum[TOTAL_WIDTH-1:0];
		end
	end

	assign ready = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			out_valid <= 1'b0;
		end else if (take) begin
			total_q   <= last ? '0 : (has_result ? sat : base);
			out_valid <= has_result;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_result) begin
			window_min    <= min_in;
			window_max    <= max_in;
			pair_sum      <= pair;
			running_total <= sat;
			is_last       <= last;
		end
	end

endmodule

>>> hw/rtl/sliding_window_min_max_sum.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_sum
// windowed minimum, maximum, their sum and a saturating running total
// ----------------------------------------------------------------------------
// result path: a sample's extremes pass the stage 1 register, then the output register
// throughput: one sample per cycle while in_stall is low (no trimming, no back-pressure)
// after the window shrinks, stale deque entries beyond the first are trimmed under in_stall
// reset: window_size is 4, both deques empty, position, fill count and total zero
// ----------------------------------------------------------------------------
module sliding_window_min_max_sum import swmm_pkg::*; #(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic        [CFG_WIDTH-1:0]    cfg_data,
	// sample channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           start_req,
	input  logic                           final_req,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] window_min,
	output logic signed [SAMPLE_WIDTH-1:0] window_max,
	output logic signed [SAMPLE_WIDTH:0]   pair_sum,
	output logic signed [TOTAL_WIDTH-1:0]  running_total,
	output logic                           is_last
);

	localparam int PW  = $clog2(2 * WINDOW_MAX);      // position bits
	localparam int SCW = $clog2(WINDOW_MAX + 1);      // fill count bits

	logic [CFG_WIDTH-1:0] window_size_q;
	logic [PW-1:0]        position_q;
	logic [SCW-1:0]       seen_q;

	// sample stage ahead of the accumulator
	logic                           valid_s1;
	logic                           start_s1;
	logic                           last_s1;
	logic                           res_s1;
	logic signed [SAMPLE_WIDTH-1:0] min_s1;
	logic signed [SAMPLE_WIDTH-1:0] max_s1;

	logic                           load;
	logic                           take;
	logic                           acc_ready;
	swmm_ctrl_t                     ctrl;
	logic [PW-1:0]                  k;
	logic [31:0]                    ws32;
	logic [PW-1:0]                  pos_base;
	logic [PW-1:0]                  pos_next;
	logic [SCW-1:0]                 seen_base;
	logic [SCW-1:0]                 seen_next;
	logic                           has_result;
	logic signed [SAMPLE_WIDTH-1:0] max_front;
	logic signed [SAMPLE_WIDTH-1:0] min_front;
	logic                           max_front_valid;
	logic                           min_front_valid;
	logic                           max_trim;
	logic                           min_trim;
	logic                           trim;

	assign cfg_ready = 1'b1;

	// effective window: zero acts as one, oversize clamps to the deque depth
	always_comb begin
		ws32 = 32'(window_size_q);
		if (ws32 == 32'd0) begin
			k = PW'(1);
		end else if (ws32 > 32'(WINDOW_MAX)) begin
			k = PW'(WINDOW_MAX);
		end else begin
			k = PW'(ws32);
		end
	end

	// stale entries left by a shrunk window are trimmed before the next sample
	assign trim     = max_trim || min_trim;
	assign take     = valid_s1 && acc_ready;
	assign in_stall = trim || (valid_s1 && !acc_ready);
	assign load     = in_valid && !in_stall;

	assign ctrl.load  = load;
	assign ctrl.start = start_req;
	assign ctrl.last  = final_req;

	// position and fill count seen by this sample, then advanced
	always_comb begin
		pos_base  = start_req ? '0 : position_q;
		seen_base = start_req ? '0 : seen_q;
		if (32'(pos_base) == 32'(2 * WINDOW_MAX - 1)) begin
			pos_next = '0;
		end else begin
			pos_next = pos_base + PW'(1);
		end
		if (32'(seen_base) < 32'(WINDOW_MAX)) begin
			seen_next = seen_base + SCW'(1);
		end else begin
			seen_next = seen_base;
		end
		has_result = 32'(seen_next) >= 32'(k);
	end

	swmm_chain #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.IS_MAX      (1'b1)
	) u_max_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample     (sample),
		.pos        (position_q),
		.k          (k),
		.front_value(max_front),
		.front_valid(max_front_valid),
		.trim_need  (max_trim)
	);

	swmm_chain #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.IS_MAX      (1'b0)
	) u_min_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample     (sample),
		.pos        (position_q),
		.k          (k),
		.front_value(min_front),
		.front_valid(min_front_valid),
		.trim_need  (min_trim)
	);

	// config register and sequence counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
			position_q    <= '0;
			seen_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_size_q <= cfg_data;
			end
			if (load) begin
				position_q <= final_req ? '0 : pos_next;
				seen_q     <= final_req ? '0 : seen_next;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload: window extremes after this sample's deque update
	always_ff @(posedge clk) begin
		if (load) begin
			start_s1 <= start_req;
			last_s1  <= final_req;
			res_s1   <= has_result;
			min_s1   <= min_front;
			max_s1   <= max_front;
		end
	end

	swmm_acc #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.start        (start_s1),
		.last         (last_s1),
		.has_result   (res_s1),
		.min_in       (min_s1),
		.max_in       (max_s1),
		.out_stall    (out_stall),
		.ready        (acc_ready),
		.out_valid    (out_valid),
		.window_min   (window_min),
		.window_max   (window_max),
		.pair_sum     (pair_sum),
		.running_total(running_total),
		.is_last      (is_last)
	);

	// position tracks the fill count until the window depth is reached
	a_pos_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(seen_q) < 32'(WINDOW_MAX)) |-> (32'(position_q) == 32'(seen_q)))
		else $error("position and fill count disagree");

	// the last sample of a sequence leaves counters and deques empty
	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(load && final_req) |=> (position_q == '0 && seen_q == '0
		&& !max_front_valid && !min_front_valid))
		else $error("sequence state not cleared after final sample");

	// any other sample leaves its own entry in both deques
	a_front_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !final_req) |=> (max_front_valid && min_front_valid))
		else $error("deque empty after a sample");

	// a delivered window never has its minimum above its maximum
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (window_min <= window_max))
		else $error("window minimum above maximum");

endmodule
